@@ sv/spq_pkg.sv @@
// Package for the sorted priority queue: operation codes, status codes, cell control.
`timescale 1ns / 1ps
`default_nettype none
package spq_pkg;

   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_PEEK   = 2'd1,
      OP_POP    = 2'd2,
      OP_CLEAR  = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   localparam int HEAD_W  = 32;
   localparam int COUNT_W = 5;

   // shift commands broadcast to every cell
   typedef struct packed {
      logic ins;
      logic pop;
   } spq_ctrl_type;

endpackage
`default_nettype wire

@@ sv/spq_cell.sv @@
// One queue cell: holds one value and shifts left or right with its neighbors.
`timescale 1ns / 1ps
`default_nettype none
module spq_cell import spq_pkg::*; #(
   parameter int VALUE_WIDTH = 32
) (
   input  wire logic                          clock,
   input  wire spq_ctrl_type                  ctrl,
   input  wire logic                          occupied,
   input  wire logic signed [VALUE_WIDTH-1:0] new_value,
   input  wire logic signed [VALUE_WIDTH-1:0] left_value,
   input  wire logic signed [VALUE_WIDTH-1:0] right_value,
   input  wire logic                          left_place,
   output      logic signed [VALUE_WIDTH-1:0] value,
   output      logic                          place
);

   logic signed [VALUE_WIDTH-1:0] value_ff;
   logic signed [VALUE_WIDTH-1:0] value_in;

   // new word belongs at or before this slot
   assign place = !occupied || (new_value <= value_ff);

   always_comb begin
      value_in = value_ff;
      if (ctrl.ins) begin
         if (left_place) begin
            value_in = left_value;
         end else if (place) begin
            value_in = new_value;
         end
      end else if (ctrl.pop) begin
         value_in = right_value;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value = value_ff;

endmodule
`default_nettype wire

@@ sv/sorted_priority_queue.sv @@
// Top level of the sorted minimum priority queue built as a row of shifting cells.
// A word accepted at a clock edge has its registered result on the rsp_ ports after that edge.
// Throughput: one word per cycle while no result waits on rsp_stall; every cell compares and shifts in the same cycle.
// A result waiting on rsp_stall holds req_stall high until it is taken.
// Reset (synchronous, active high) empties the queue and drops any pending result.
// Cell contents are not reset; only slots below the count ever reach a result.
`timescale 1ns / 1ps
`default_nettype none
module sorted_priority_queue import spq_pkg::*; #(
   parameter int DEPTH       = 16,
   parameter int VALUE_WIDTH = 32
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output      logic                req_stall,
   input  wire logic [1:0]          req_op,
   input  wire logic signed [31:0]  req_value,
   output      logic                rsp_valid,
   input  wire logic                rsp_stall,
   output      logic signed [HEAD_W-1:0] rsp_head_value,
   output      logic                rsp_is_empty,
   output      logic [1:0]          rsp_status,
   output      logic [COUNT_W-1:0]  rsp_count
);

   localparam int CW = $clog2(DEPTH + 1);

   // control state
   logic [CW-1:0] count_ff, count_in;
   logic          rsp_valid_ff, rsp_valid_in;

   // result word register
   logic signed [HEAD_W-1:0] head_ff, head_in;
   logic                     empty_ff, empty_in;
   status_type               status_ff, status_in;
   logic [COUNT_W-1:0]       rcount_ff, rcount_in;

   logic                          accept;
   op_type                        op;
   logic signed [VALUE_WIDTH-1:0] new_value;
   logic                          is_full, is_none;
   logic                          ins_go, pop_go;
   spq_ctrl_type                  ctrl;
   logic [VALUE_WIDTH-1:0]        head_vw;

   logic signed [VALUE_WIDTH-1:0] cell_val [DEPTH];
   logic                          cell_place [DEPTH];

   // Input side stalls only while a finished result sits unclaimed.
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;
   assign op        = op_type'(req_op);

   // sign-extend or truncate to the stored width
   assign new_value = VALUE_WIDTH'(req_value);

   assign is_full = (count_ff == CW'(DEPTH));
   assign is_none = (count_ff == '0);

   assign ins_go = accept && (op == OP_INSERT) && !is_full;
   assign pop_go = accept && (op == OP_POP) && !is_none;

   assign ctrl.ins = ins_go;
   assign ctrl.pop = pop_go;

   // The row of cells. Cell 0 is the head. On insert every slot at or past
   // the insertion point moves one step right; on pop everything moves left.
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic signed [VALUE_WIDTH-1:0] left_v, right_v;
      logic                          left_p;
      logic                          occ;

      if (i == 0) begin : g_first
         assign left_v = new_value;
         assign left_p = 1'b0;
      end else begin : g_mid
         assign left_v = cell_val[i-1];
         assign left_p = cell_place[i-1];
      end

      if (i == DEPTH - 1) begin : g_last
         assign right_v = cell_val[i];
      end else begin : g_notlast
         assign right_v = cell_val[i+1];
      end

      assign occ = (CW'(i) < count_ff);

      spq_cell #(
         .VALUE_WIDTH(VALUE_WIDTH)
      ) u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .occupied   (occ),
         .new_value  (new_value),
         .left_value (left_v),
         .right_value(right_v),
         .left_place (left_p),
         .value      (cell_val[i]),
         .place      (cell_place[i])
      );
   end

   // next count, head and status as they stand after this word
   always_comb begin
      count_in  = count_ff;
      status_in = ST_OK;
      head_vw   = cell_val[0];
      case (op)
         OP_INSERT: begin
            if (is_full) begin
               status_in = ST_FULL;
            end else begin
               count_in = count_ff + CW'(1);
               if (cell_place[0]) begin
                  head_vw = new_value;
               end
            end
         end
         OP_PEEK: begin
            if (is_none) begin
               status_in = ST_EMPTY;
            end
         end
         OP_POP: begin
            if (is_none) begin
               status_in = ST_EMPTY;
            end else begin
               count_in = count_ff - CW'(1);
               head_vw  = cell_val[1];
            end
         end
         default: begin
            count_in = '0;
         end
      endcase
      if (!accept) begin
         count_in = count_ff;
      end
   end

   assign empty_in  = (count_in == '0);
   // stored bits, zero-extended or cut to the head field
   assign head_in   = empty_in ? '0 : HEAD_W'(head_vw);
   assign rcount_in = COUNT_W'(count_in);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         head_ff   <= head_in;
         empty_ff  <= empty_in;
         status_ff <= status_in;
         rcount_ff <= rcount_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_head_value = head_ff;
   assign rsp_is_empty   = empty_ff;
   assign rsp_status     = status_ff;
   assign rsp_count      = rcount_ff;

endmodule
`default_nettype wire

@@ sv/spq_checker.sv @@
// Port-level checks for the sorted priority queue, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module spq_checker import spq_pkg::*; (
   input wire logic                     clock,
   input wire logic                     reset,
   input wire logic                     req_valid,
   input wire logic                     req_stall,
   input wire logic                     rsp_valid,
   input wire logic                     rsp_stall,
   input wire logic signed [HEAD_W-1:0] rsp_head_value,
   input wire logic                     rsp_is_empty,
   input wire logic [1:0]               rsp_status,
   input wire logic [COUNT_W-1:0]       rsp_count
);

   // stalled result word holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_head_value)
         && $stable(rsp_status) && $stable(rsp_count) && $stable(rsp_is_empty))
      else $error("stalled result changed");

   // empty queue reports zero head and zero count
   a_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_empty |-> (rsp_head_value == '0) && (rsp_count == '0))
      else $error("empty result with data");

   // a dropped insert means the queue is holding values
   a_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_FULL) |-> !rsp_is_empty)
      else $error("full status on empty queue");

   // no result ever appears right after reset
   a_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result after reset");

   // input stalls only when a result is waiting
   a_stall: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled without pending result");

endmodule

bind sorted_priority_queue spq_checker u_spq_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_stall     (req_stall),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_head_value(rsp_head_value),
   .rsp_is_empty  (rsp_is_empty),
   .rsp_status    (rsp_status),
   .rsp_count     (rsp_count)
);
`default_nettype wire
